@@ hw/rtl/flna_pkg.sv @@
// shared types and constants of the number-to-ascii unit
`default_nettype none

package flna_pkg;

  typedef enum logic [1:0] {
    CMD_UDEC = 2'd0,
    CMD_SDEC = 2'd1,
    CMD_HEX  = 2'd2,
    CMD_BIN  = 2'd3
  } cmd_t;

  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;

  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned HEX_DIGITS = 8;
  localparam int unsigned BIN_DIGITS = 16;

  localparam int unsigned BCD_W = 4 * DEC_DIGITS;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_sign;
    logic emit_digit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_dec;
    logic is_signed;
    logic cnt_zero;
    logic idx_zero;
    logic bit_last;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/fixed_length_number_to_ascii_unit.sv @@
// top level of the fixed-length number to ascii converter
//
//   channel   ports                                        handshake
//   input     in_command in_value in_digit_count           start & !busy
//             in_row in_start_col
//   result    out_row out_col out_glyph_code out_last      out_valid strobe, one cycle
//
// one beat in, then one result beat per character, most significant digit first
// per item: accept, decode in the load state, then in decimal modes VALUE_WIDTH
//   shift-add-3 steps in the bcd converter, then a sign beat in signed mode and
//   one beat per digit
// synchronous active-low reset returns the controller to idle and drops out_valid
// the receiver cannot stall: each result beat is taken in its own cycle
`default_nettype none

module fixed_length_number_to_ascii_unit
  import flna_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_value,
  input  wire logic [4:0]  in_digit_count,
  input  wire logic [2:0]  in_row,
  input  wire logic [4:0]  in_start_col,
  output logic             out_valid,
  output logic [2:0]       out_row,
  output logic [4:0]       out_col,
  output logic [6:0]       out_glyph_code,
  output logic             out_last
);

  // command and status between controller and datapath
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: decides conversion, sign beat and digit beats
  flna_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // operand registers, bcd converter and registered result beat
  flna_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_command     (in_command),
    .in_value       (in_value),
    .in_digit_count (in_digit_count),
    .in_row         (in_row),
    .in_start_col   (in_start_col),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_glyph_code (out_glyph_code),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

@@ hw/rtl/flna_dp.sv @@
// datapath: operand registers, shift-add-3 bcd converter, digit select and output beat
`default_nettype none

module flna_dp
  import flna_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctrl_cmd_t   cmd,
  output dp_status_t       status,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_value,
  input  wire logic [4:0]  in_digit_count,
  input  wire logic [2:0]  in_row,
  input  wire logic [4:0]  in_start_col,
  output logic             out_valid,
  output logic [2:0]       out_row,
  output logic [4:0]       out_col,
  output logic [6:0]       out_glyph_code,
  output logic             out_last
);

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned BCW = $clog2(VALUE_WIDTH);

  cmd_t              mode_r;
  logic [VW-1:0]     val_r;
  logic [BCD_W-1:0]  bcd_r;
  logic [3:0]        idx_r;
  logic              cnt_zero_r;
  logic              neg_r;
  logic [2:0]        row_r;
  logic [4:0]        col_r;
  logic [BCW-1:0]    bit_cnt_r;

  logic              out_valid_r;
  logic [2:0]        out_row_r;
  logic [4:0]        out_col_r;
  logic [6:0]        out_glyph_r;
  logic              out_last_r;

  logic [VW-1:0]     vin;
  logic [31:0]       low32;
  logic              in_neg;
  logic [4:0]        limit;
  logic [4:0]        clamped;
  logic [BCD_W-1:0]  bcd_adj;
  logic [63:0]       dec_pad;
  logic [63:0]       hex_pad;
  logic [15:0]       bin16;
  logic [3:0]        digit;
  logic [6:0]        digit_glyph;

  // input value and low word of the held value at the configured width
  if (VW >= 32) begin : g_wide
    assign vin   = VW'(in_value);
    assign low32 = val_r[31:0];
  end else begin : g_narrow
    assign vin   = in_value[VW-1:0];
    assign low32 = {{(32-VW){1'b0}}, val_r};
  end

  assign in_neg = (cmd_t'(in_command) == CMD_SDEC) && vin[VW-1];

  always_comb begin
    unique case (cmd_t'(in_command))
      CMD_UDEC, CMD_SDEC: limit = 5'(DEC_DIGITS);
      CMD_HEX:            limit = 5'(HEX_DIGITS);
      CMD_BIN:            limit = 5'(BIN_DIGITS);
      default:            limit = 5'(BIN_DIGITS);
    endcase
    clamped = (in_digit_count > limit) ? limit : in_digit_count;
  end

  // add 3 to every bcd digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < DEC_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3
                                                       : bcd_r[4*d +: 4];
    end
  end

  assign dec_pad = {{(64-BCD_W){1'b0}}, bcd_r};
  assign hex_pad = {32'd0, low32};
  assign bin16   = low32[15:0];

  always_comb begin
    case (mode_r)
      CMD_UDEC, CMD_SDEC: digit = dec_pad[{idx_r, 2'b00} +: 4];
      CMD_HEX:            digit = hex_pad[{idx_r, 2'b00} +: 4];
      default:            digit = {3'b000, bin16[idx_r]};
    endcase
    digit_glyph = (digit < 4'd10) ? CH_ZERO + 7'(digit) : CH_A + 7'(digit - 4'd10);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= cmd_t'(in_command);
      val_r      <= in_neg ? ('0 - vin) : vin;
      neg_r      <= in_neg;
      bcd_r      <= '0;
      idx_r      <= 4'(clamped - 5'd1);
      cnt_zero_r <= (clamped == 5'd0);
      row_r      <= in_row;
      col_r      <= in_start_col;
      bit_cnt_r  <= BCW'(VW - 1);
    end else if (cmd.conv_step) begin
      bcd_r     <= {bcd_adj[BCD_W-2:0], val_r[VW-1]};
      val_r     <= {val_r[VW-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r - BCW'(1);
    end else if (cmd.emit_sign) begin
      col_r <= col_r + 5'd1;
    end else if (cmd.emit_digit) begin
      col_r <= col_r + 5'd1;
      idx_r <= idx_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_sign | cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_row_r   <= row_r;
      out_col_r   <= col_r;
      out_glyph_r <= neg_r ? CH_MINUS : CH_PLUS;
      out_last_r  <= cnt_zero_r;
    end else if (cmd.emit_digit) begin
      out_row_r   <= row_r;
      out_col_r   <= col_r;
      out_glyph_r <= digit_glyph;
      out_last_r  <= (idx_r == 4'd0);
    end
  end

  assign status.is_dec    = (mode_r == CMD_UDEC) || (mode_r == CMD_SDEC);
  assign status.is_signed = (mode_r == CMD_SDEC);
  assign status.cnt_zero  = cnt_zero_r;
  assign status.idx_zero  = (idx_r == 4'd0);
  assign status.bit_last  = (bit_cnt_r == '0);

  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_glyph_code = out_glyph_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

@@ hw/rtl/flna_ctrl.sv @@
// controller state machine: load, convert, sign and digit sequencing
`default_nettype none

module flna_ctrl
  import flna_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  output ctrl_cmd_t       cmd,
  input  wire dp_status_t status
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_CONV  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.is_dec && !status.cnt_zero) state_nxt = ST_CONV;
        else if (status.is_signed)             state_nxt = ST_SIGN;
        else if (!status.cnt_zero)             state_nxt = ST_DIGIT;
        else                                   state_nxt = ST_IDLE;
      end
      ST_CONV: begin
        if (status.bit_last) state_nxt = status.is_signed ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        state_nxt = status.cnt_zero ? ST_IDLE : ST_DIGIT;
      end
      ST_DIGIT: begin
        if (status.idx_zero) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign cmd.load       = (state_r == ST_IDLE) && start;
  assign cmd.conv_step  = (state_r == ST_CONV);
  assign cmd.emit_sign  = (state_r == ST_SIGN);
  assign cmd.emit_digit = (state_r == ST_DIGIT);

endmodule

`default_nettype wire
